// File: src/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SRFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/srfr_pkg.sv
package srfr_pkg;

  localparam int MAX_RES = 5;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  // result kinds
  localparam logic [1:0] KIND_TX       = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
  localparam logic [1:0] KIND_VERIFIED = 2'd2;
  localparam logic [1:0] KIND_ABORTED  = 2'd3;

  // protocol bytes
  localparam logic [7:0] SYNC_B0  = 8'hff;
  localparam logic [7:0] SYNC_B1  = 8'hfe;
  localparam logic [7:0] SYNC_B2  = 8'hfd;
  localparam logic [7:0] SYNC_B3  = 8'hfc;
  localparam logic [7:0] MARK_B   = 8'hfb;
  localparam logic [7:0] TERM_B   = 8'hfa;
  localparam logic [7:0] HS_REP_B = 8'hf9;
  localparam logic [7:0] HS_B1    = 8'h03;
  localparam logic [7:0] HS_B2    = 8'h02;
  localparam logic [7:0] ERR_B    = 8'hef;

  // configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_HDR_TIMEOUT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BODY_TIMEOUT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HS_CMD       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_VER_MAJOR    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_VER_MINOR    = 3'd4;

  typedef struct packed {
    logic [15:0] hdr_timeout;
    logic [15:0] body_timeout;
    logic [7:0]  hs_cmd;
    logic [7:0]  ver_major;
    logic [7:0]  ver_minor;
  } cfg_t;

  // words caused by one input, slot 0 goes out first
  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    logic [MAX_RES-1:0][1:0]   kind;
    logic [MAX_RES-1:0][7:0]   value;
    logic [7:0]                cmd;
    logic [7:0]                len;
  } res_list_t;

endpackage

// File: src/serial_request_frame_receiver.sv
// an accepted word waits in the input register, then loads into the free output buffer
// throughput: one input word per cycle while each causes at most one result
//   and out_tready is high; n results (up to 5) hold the result register until taken
// reset: synchronous active-low rst_n returns to sync hunt, clears all counters and sums
//   and loads register defaults 30000, 60000, 1, 1, 2
module serial_request_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] value, [15:8] command, [23:16] length
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [srfr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [15:0] cfg_wdata
);

  srfr_pkg::cfg_t      cfg_r;
  srfr_pkg::res_list_t list;
  logic                in_vld_r;
  logic                in_mode_r;
  logic [7:0]          in_byte_r;
  logic                buf_free;
  logic                consume;
  logic [7:0]          out_value, out_cmd, out_len;

  assign consume   = in_vld_r && buf_free;
  assign in_tready = !in_vld_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hdr_timeout  <= 16'd30000;
      cfg_r.body_timeout <= 16'd60000;
      cfg_r.hs_cmd       <= 8'd1;
      cfg_r.ver_major    <= 8'd1;
      cfg_r.ver_minor    <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_addr)
        srfr_pkg::CFG_HDR_TIMEOUT:  cfg_r.hdr_timeout  <= cfg_wdata;
        srfr_pkg::CFG_BODY_TIMEOUT: cfg_r.body_timeout <= cfg_wdata;
        srfr_pkg::CFG_HS_CMD:       cfg_r.hs_cmd       <= cfg_wdata[7:0];
        srfr_pkg::CFG_VER_MAJOR:    cfg_r.ver_major    <= cfg_wdata[7:0];
        srfr_pkg::CFG_VER_MINOR:    cfg_r.ver_minor    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (consume) begin
      in_vld_r <= 1'b0;
    end
    if (in_tvalid && in_tready) begin
      in_mode_r <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  srfr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (consume),
    .mode    (in_mode_r),
    .rx_byte (in_byte_r),
    .cfg     (cfg_r),
    .list    (list)
  );

  srfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (consume),
    .list      (list),
    .free      (buf_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_value (out_value),
    .out_cmd   (out_cmd),
    .out_len   (out_len),
    .out_last  (out_tlast)
  );

  assign out_tdata = {out_len, out_cmd, out_value};

endmodule

// File: src/srfr_core.sv
module srfr_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                mode,
  input  logic [7:0]          rx_byte,
  input  srfr_pkg::cfg_t      cfg,
  output srfr_pkg::res_list_t list
);

  typedef enum logic [3:0] {
    PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3,
    PH_MARK, PH_CMD, PH_LEN, PH_BLOCK, PH_TERM
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [8:0]  count_r, count_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  sum_lo_r, sum_lo_nxt;
  logic [7:0]  sum_hi_r, sum_hi_nxt;
  logic [7:0]  first_r, first_nxt;
  logic        match_r, match_nxt;
  logic [15:0] wait_r, wait_nxt;

  logic [7:0]  lo_add, hi_add, c0, c1;
  logic [15:0] wait_inc, limit;
  logic [8:0]  len_plus2;
  logic        in_wait;

  // operands stay below 2*255, so one conditional subtract does it
  function automatic logic [7:0] mod255(input logic [8:0] x);
    logic [8:0] d;
    d = x - 9'd255;
    mod255 = (x >= 9'd255) ? d[7:0] : x[7:0];
  endfunction

  always_comb begin
    lo_add    = mod255({1'b0, sum_lo_r} + {1'b0, rx_byte});
    hi_add    = mod255({1'b0, sum_hi_r} + {1'b0, lo_add});
    c0        = 8'hff - mod255({1'b0, sum_lo_r} + {1'b0, sum_hi_r});
    c1        = 8'hff - mod255({1'b0, sum_lo_r} + {1'b0, c0});
    wait_inc  = (wait_r != 16'hffff) ? wait_r + 16'd1 : wait_r;
    in_wait   = (phase_r >= PH_MARK) && (phase_r <= PH_TERM);
    limit     = (phase_r <= PH_LEN) ? cfg.hdr_timeout : cfg.body_timeout;
    len_plus2 = {1'b0, len_r} + 9'd2;

    phase_nxt  = phase_r;
    count_nxt  = count_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    sum_lo_nxt = sum_lo_r;
    sum_hi_nxt = sum_hi_r;
    first_nxt  = first_r;
    match_nxt  = match_r;
    wait_nxt   = wait_r;

    list.cnt   = '0;
    list.kind  = '0;
    list.value = '0;

    if (mode) begin
      if (in_wait) begin
        wait_nxt = wait_inc;
        if (wait_inc >= limit) begin
          list.value[0] = srfr_pkg::ERR_B;
          list.value[1] = srfr_pkg::ERR_B;
          list.value[2] = srfr_pkg::ERR_B;
          list.cnt      = srfr_pkg::CNT_W'(3);
          if (phase_r >= PH_BLOCK) begin
            list.kind[3] = srfr_pkg::KIND_ABORTED;
            list.cnt     = srfr_pkg::CNT_W'(4);
          end
          phase_nxt = PH_SYNC0;
          wait_nxt  = '0;
        end
      end
    end else begin
      case (phase_r)
        PH_SYNC0: begin
          phase_nxt = (rx_byte == srfr_pkg::SYNC_B0) ? PH_SYNC1 : PH_SYNC0;
          wait_nxt  = '0;
        end
        PH_SYNC1: begin
          phase_nxt = (rx_byte == srfr_pkg::SYNC_B1) ? PH_SYNC2 : PH_SYNC0;
          wait_nxt  = '0;
        end
        PH_SYNC2: begin
          phase_nxt = (rx_byte == srfr_pkg::SYNC_B2) ? PH_SYNC3 : PH_SYNC0;
          wait_nxt  = '0;
        end
        PH_SYNC3: begin
          wait_nxt = '0;
          if (rx_byte != srfr_pkg::SYNC_B3) begin
            phase_nxt = PH_SYNC0;
          end else begin
            // echo the pattern back reversed
            list.value[0] = srfr_pkg::SYNC_B3;
            list.value[1] = srfr_pkg::SYNC_B2;
            list.value[2] = srfr_pkg::SYNC_B1;
            list.value[3] = srfr_pkg::SYNC_B0;
            list.cnt      = srfr_pkg::CNT_W'(4);
            cmd_nxt       = '0;
            len_nxt       = '0;
            phase_nxt     = PH_MARK;
          end
        end
        PH_MARK: begin
          if (rx_byte != srfr_pkg::MARK_B) begin
            phase_nxt = PH_SYNC0;
            wait_nxt  = '0;
          end else begin
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt   = rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt       = rx_byte;
          list.value[0] = rx_byte;
          list.value[1] = cmd_r;
          list.value[2] = srfr_pkg::MARK_B;
          list.cnt      = srfr_pkg::CNT_W'(3);
          phase_nxt     = PH_BLOCK;
          wait_nxt      = '0;
          count_nxt     = '0;
          sum_lo_nxt    = '0;
          sum_hi_nxt    = '0;
          first_nxt     = '0;
          match_nxt     = 1'b1;
        end
        PH_BLOCK: begin
          if (count_r < len_plus2) begin
            if (count_r == 9'd0 && rx_byte != cmd_r) match_nxt = 1'b0;
            if (count_r == 9'd1 && rx_byte != len_r) match_nxt = 1'b0;
            if (count_r >= 9'd2 && cmd_r != cfg.hs_cmd) begin
              list.kind[0]  = srfr_pkg::KIND_PAYLOAD;
              list.value[0] = rx_byte;
              list.cnt      = srfr_pkg::CNT_W'(1);
            end
            sum_lo_nxt = lo_add;
            sum_hi_nxt = hi_add;
          end else if (count_r == len_plus2) begin
            first_nxt = rx_byte;
          end else begin
            if (c0 != first_r || c1 != rx_byte) match_nxt = 1'b0;
            phase_nxt = PH_TERM;
            wait_nxt  = '0;
          end
          count_nxt = count_r + 9'd1;
        end
        PH_TERM: begin
          if (rx_byte != srfr_pkg::TERM_B) begin
            list.kind[0] = srfr_pkg::KIND_ABORTED;
            list.cnt     = srfr_pkg::CNT_W'(1);
          end else if (!match_r) begin
            list.value[0] = srfr_pkg::ERR_B;
            list.value[1] = srfr_pkg::ERR_B;
            list.value[2] = srfr_pkg::ERR_B;
            list.kind[3]  = srfr_pkg::KIND_ABORTED;
            list.cnt      = srfr_pkg::CNT_W'(4);
          end else if (cmd_r == cfg.hs_cmd) begin
            list.value[0] = srfr_pkg::HS_REP_B;
            list.value[1] = srfr_pkg::HS_B1;
            list.value[2] = srfr_pkg::HS_B2;
            list.value[3] = cfg.ver_major;
            list.value[4] = cfg.ver_minor;
            list.cnt      = srfr_pkg::CNT_W'(5);
          end else begin
            list.kind[0] = srfr_pkg::KIND_VERIFIED;
            list.cnt     = srfr_pkg::CNT_W'(1);
          end
          phase_nxt = PH_SYNC0;
          wait_nxt  = '0;
        end
        default: begin
          phase_nxt = PH_SYNC0;
          wait_nxt  = '0;
        end
      endcase
    end

    list.cmd = cmd_nxt;
    list.len = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC0;
      count_r  <= '0;
      cmd_r    <= '0;
      len_r    <= '0;
      sum_lo_r <= '0;
      sum_hi_r <= '0;
      first_r  <= '0;
      match_r  <= 1'b1;
      wait_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      cmd_r    <= cmd_nxt;
      len_r    <= len_nxt;
      sum_lo_r <= sum_lo_nxt;
      sum_hi_r <= sum_hi_nxt;
      first_r  <= first_nxt;
      match_r  <= match_nxt;
      wait_r   <= wait_nxt;
    end
  end

endmodule

// File: src/srfr_out_buf.sv
`include "assert_macros.svh"

module srfr_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  srfr_pkg::res_list_t list,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_value,
  output logic [7:0]          out_cmd,
  output logic [7:0]          out_len,
  output logic                out_last
);

  logic                                    vld_r, vld_nxt;
  logic [srfr_pkg::CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [srfr_pkg::MAX_RES-1:0][1:0]       kind_r, kind_nxt;
  logic [srfr_pkg::MAX_RES-1:0][7:0]       value_r, value_nxt;
  logic [7:0]                              cmd_r, cmd_nxt;
  logic [7:0]                              len_r, len_nxt;
  logic                                    pop;

  assign out_valid = vld_r;
  assign out_last  = (cnt_r == srfr_pkg::CNT_W'(1));
  assign out_kind  = kind_r[0];
  assign out_value = value_r[0];
  assign out_cmd   = cmd_r;
  assign out_len   = len_r;
  assign pop       = vld_r && out_ready;
  // free when empty or once the final word of the current list is being taken
  assign free      = !vld_r || (out_ready && out_last);

  always_comb begin
    vld_nxt   = vld_r;
    cnt_nxt   = cnt_r;
    kind_nxt  = kind_r;
    value_nxt = value_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    if (load) begin
      vld_nxt   = (list.cnt != '0);
      cnt_nxt   = list.cnt;
      kind_nxt  = list.kind;
      value_nxt = list.value;
      cmd_nxt   = list.cmd;
      len_nxt   = list.len;
    end else if (pop) begin
      if (out_last) begin
        vld_nxt = 1'b0;
      end
      cnt_nxt = cnt_r - srfr_pkg::CNT_W'(1);
      for (int i = 0; i < srfr_pkg::MAX_RES - 1; i++) begin
        kind_nxt[i]  = kind_r[i+1];
        value_nxt[i] = value_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
    end
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    cmd_r   <= cmd_nxt;
    len_r   <= len_nxt;
  end

  `SRFR_ASSERT_IMP(a_cnt_range, vld_r, (cnt_r != '0) && (cnt_r <= srfr_pkg::CNT_W'(srfr_pkg::MAX_RES)), "word count out of range while valid")
  `SRFR_ASSERT_IMP(a_load_free, load, free, "list loaded over undelivered words")
  `SRFR_ASSERT_NXT(a_drain, pop && out_last && !load, !vld_r, "buffer not empty after final word")
  `SRFR_ASSERT_NXT(a_advance, pop && !out_last, vld_r && (cnt_r + srfr_pkg::CNT_W'(1) == $past(cnt_r)), "buffer did not advance by one word")

endmodule
